// ===== hdl/mfp_pkg.sv =====
`timescale 1ns / 1ps

package mfp_pkg;

   localparam int MAX_FRAME_BYTES = 280;
   localparam int CNT_BITS = $clog2(MAX_FRAME_BYTES + 1);
   // counter must also hold the longest legal frame (280)
   localparam int CNT_W = (CNT_BITS > 9) ? CNT_BITS : 9;

   localparam logic [7:0] MAGIC_V1 = 8'hFE;
   localparam logic [7:0] MAGIC_V2 = 8'hFD;

   localparam logic [3:0] V1_OVERHEAD = 4'd8;
   localparam logic [3:0] V2_OVERHEAD = 4'd12;
   localparam logic [3:0] SIG_BYTES   = 4'd13;
   localparam logic [3:0] V1_HDR_LEN  = 4'd6;
   localparam logic [3:0] V2_HDR_LEN  = 4'd10;
   localparam logic [3:0] HB_OFFSET   = 4'd4;
   localparam logic [7:0] HB_MIN_LEN  = 8'd9;
   localparam int         HB_ARMED_BIT = 7;
   localparam int         SIGNED_FLAG_BIT = 0;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   localparam int HDR_BYTES = 10;
   localparam int HDR_IDX_W = $clog2(HDR_BYTES);
   localparam int HB_BYTES  = 3;

   localparam int XTAB_DEPTH = 100;

   localparam logic [8:0] XID_TAB [XTAB_DEPTH] = '{
      9'd0,   9'd1,   9'd2,   9'd4,   9'd11,  9'd20,  9'd21,  9'd22,  9'd23,  9'd24,
      9'd25,  9'd26,  9'd27,  9'd29,  9'd30,  9'd31,  9'd32,  9'd33,  9'd35,  9'd36,
      9'd37,  9'd38,  9'd39,  9'd40,  9'd41,  9'd42,  9'd43,  9'd44,  9'd45,  9'd46,
      9'd47,  9'd51,  9'd62,  9'd65,  9'd66,  9'd69,  9'd70,  9'd73,  9'd74,  9'd75,
      9'd76,  9'd77,  9'd82,  9'd84,  9'd86,  9'd109, 9'd110, 9'd111, 9'd125, 9'd126,
      9'd147, 9'd148, 9'd152, 9'd193, 9'd230, 9'd231, 9'd241, 9'd242, 9'd245, 9'd253,
      9'd254, 9'd256, 9'd257, 9'd258, 9'd259, 9'd260, 9'd261, 9'd262, 9'd263, 9'd264,
      9'd265, 9'd266, 9'd267, 9'd268, 9'd269, 9'd270, 9'd280, 9'd281, 9'd282, 9'd283,
      9'd284, 9'd285, 9'd286, 9'd287, 9'd288, 9'd299, 9'd301, 9'd310, 9'd311, 9'd320,
      9'd321, 9'd322, 9'd323, 9'd324, 9'd330, 9'd331, 9'd332, 9'd333, 9'd334, 9'd335
   };

   localparam logic [7:0] XVAL_TAB [XTAB_DEPTH] = '{
      8'd50,  8'd124, 8'd137, 8'd237, 8'd89,  8'd214, 8'd159, 8'd220, 8'd168, 8'd24,
      8'd23,  8'd170, 8'd144, 8'd115, 8'd39,  8'd246, 8'd185, 8'd104, 8'd244, 8'd222,
      8'd212, 8'd9,   8'd254, 8'd230, 8'd28,  8'd28,  8'd132, 8'd221, 8'd232, 8'd11,
      8'd153, 8'd196, 8'd183, 8'd118, 8'd148, 8'd243, 8'd124, 8'd38,  8'd20,  8'd158,
      8'd152, 8'd143, 8'd49,  8'd143, 8'd5,   8'd185, 8'd84,  8'd34,  8'd203, 8'd220,
      8'd154, 8'd178, 8'd208, 8'd71,  8'd163, 8'd105, 8'd90,  8'd104, 8'd130, 8'd83,
      8'd46,  8'd71,  8'd131, 8'd187, 8'd92,  8'd146, 8'd179, 8'd12,  8'd133, 8'd49,
      8'd26,  8'd193, 8'd35,  8'd14,  8'd109, 8'd59,  8'd70,  8'd48,  8'd123, 8'd74,
      8'd99,  8'd137, 8'd210, 8'd1,   8'd20,  8'd19,  8'd243, 8'd28,  8'd95,  8'd243,
      8'd88,  8'd243, 8'd78,  8'd132, 8'd23,  8'd91,  8'd236, 8'd231, 8'd72,  8'd225
   };

   typedef enum logic [1:0] {
      CRC_UNKNOWN  = 2'd0,
      CRC_MATCH    = 2'd1,
      CRC_MISMATCH = 2'd2
   } crc_status_type;

   typedef struct packed {
      logic       known;
      logic [7:0] extra;
   } extra_info_type;

   typedef struct packed {
      logic [8:0]     frame_length;
      logic [23:0]    msg_num;
      logic [7:0]     src_sys;
      logic [7:0]     src_comp;
      logic           is_v2;
      crc_status_type crc_status;
      logic           urgent;
      logic           hb_valid;
      logic           hb_armed;
      logic [7:0]     hb_vehicle;
      logic [7:0]     hb_autopilot;
      logic [31:0]    error_total;
   } result_type;

   // CRC-16/MCRF4XX, one byte
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] d);
      logic [7:0] t;
      t = d ^ crc[7:0];
      t = t ^ {t[3:0], 4'b0000};
      return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
   endfunction

   function automatic extra_info_type lookup_extra(input logic [23:0] id);
      extra_info_type r;
      r.known = 1'b0;
      r.extra = 8'h00;
      for (int i = 0; i < XTAB_DEPTH; i++) begin
         if (id == {15'd0, XID_TAB[i]}) begin
            r.known = 1'b1;
            r.extra = XVAL_TAB[i];
         end
      end
      return r;
   endfunction

   function automatic logic in_priority_set(input logic [23:0] id);
      logic hit;
      hit = (id == 24'd11) || (id == 24'd23) || (id == 24'd69) || (id == 24'd70) ||
            (id == 24'd75) || (id == 24'd76) || (id == 24'd77);
      hit = hit || (id >= 24'd37 && id <= 24'd51);
      hit = hit || (id == 24'd66) || (id == 24'd82) || (id == 24'd84) ||
            (id == 24'd86) || (id == 24'd110);
      hit = hit || (id >= 24'd282 && id <= 24'd288);
      return hit;
   endfunction

endpackage

// ===== hdl/mfp_if.sv =====
`timescale 1ns / 1ps

interface mfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink (input valid, input byte_in, output ready);
endinterface

interface mfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [8:0]  frame_length;
   logic [23:0] msg_num;
   logic [7:0]  src_sys;
   logic [7:0]  src_comp;
   logic        is_v2;
   logic [1:0]  crc_status;
   logic        urgent;
   logic        hb_valid;
   logic        hb_armed;
   logic [7:0]  hb_vehicle;
   logic [7:0]  hb_autopilot;
   logic [31:0] error_total;

   modport source (output valid, output frame_length, output msg_num, output src_sys,
                   output src_comp, output is_v2, output crc_status, output urgent,
                   output hb_valid, output hb_armed, output hb_vehicle,
                   output hb_autopilot, output error_total, input ready);
   modport sink (input valid, input frame_length, input msg_num, input src_sys,
                 input src_comp, input is_v2, input crc_status, input urgent,
                 input hb_valid, input hb_armed, input hb_vehicle,
                 input hb_autopilot, input error_total, output ready);
endinterface

// ===== hdl/mavlink_frame_parser.sv =====
`timescale 1ns / 1ps
// A frame's result reaches the output after its last byte is accepted, through the byte
// register, then the result register.
// Throughput: one byte per cycle; set by the per-byte CRC update loop.
// Bytes keep flowing while a result waits; only a byte that ends another frame stalls.
// Reset (synchronous): hunting for a start marker, CRC 0xFFFF, error count 0.

module mavlink_frame_parser (
   input logic   clock,
   input logic   reset,
   mfp_req_if.sink   req_ch,
   mfp_rsp_if.source rsp_ch
);
   import mfp_pkg::*;

   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [8:0]       fexp_ff, fexp_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       crc_lo_ff, crc_lo_in;
   logic [31:0]      err_ff, err_in;
   logic [7:0]       hb_ff [HB_BYTES];
   logic [7:0]       hdr_ff [HDR_BYTES];

   logic             rsp_valid_ff;
   result_type       res_ff, res_in;

   logic             hdr_we;
   logic             hb_we;
   logic [1:0]       hb_idx;
   logic             emit;
   logic             advance;

   logic             v2;
   logic [3:0]       hlen;
   logic [CNT_W-1:0] crcoff;
   logic [CNT_W-1:0] cnt_inc;
   logic [23:0]      cur_id;
   extra_info_type   xinfo;
   logic             match;
   logic             hb_ok;

   assign v2      = (hdr_ff[0] == MAGIC_V2);
   assign hlen    = v2 ? V2_HDR_LEN : V1_HDR_LEN;
   assign crcoff  = CNT_W'(hlen) + CNT_W'(hdr_ff[1]);
   assign cnt_inc = cnt_ff + CNT_W'(1);
   assign cur_id  = v2 ? {hdr_ff[9], hdr_ff[8], hdr_ff[7]} : {16'h0000, hdr_ff[5]};
   assign xinfo   = lookup_extra(cur_id);

   always_comb begin
      cnt_in    = cnt_ff;
      fexp_in   = fexp_ff;
      crc_in    = crc_ff;
      crc_lo_in = crc_lo_ff;
      err_in    = err_ff;
      hdr_we    = 1'b0;
      hb_we     = 1'b0;
      hb_idx    = 2'd0;
      emit      = 1'b0;
      if (cnt_ff == '0) begin
         if (in_byte_ff == MAGIC_V1 || in_byte_ff == MAGIC_V2) begin
            hdr_we  = 1'b1;
            cnt_in  = CNT_W'(1);
            fexp_in = '0;
            crc_in  = CRC_INIT;
         end
      end else if (cnt_ff >= CNT_W'(MAX_FRAME_BYTES)) begin
         err_in  = err_ff + 32'd1;
         cnt_in  = '0;
         fexp_in = '0;
      end else begin
         hdr_we = (cnt_ff < CNT_W'(HDR_BYTES));
         cnt_in = cnt_inc;
         if (cnt_ff == CNT_W'(1)) begin
            // v2 starts from 12, v1 from 8 bytes of overhead
            fexp_in = (v2 ? 9'(V2_OVERHEAD) : 9'(V1_OVERHEAD)) + 9'(in_byte_ff);
            crc_in  = crc_step(crc_ff, in_byte_ff);
         end else begin
            if (v2 && cnt_ff == CNT_W'(2) && in_byte_ff[SIGNED_FLAG_BIT]) begin
               fexp_in = fexp_ff + 9'(SIG_BYTES);
            end
            if (cnt_ff < crcoff) begin
               crc_in = crc_step(crc_ff, in_byte_ff);
               if (cnt_ff >= CNT_W'(hlen) + CNT_W'(HB_OFFSET) &&
                   cnt_ff <= CNT_W'(hlen) + CNT_W'(HB_OFFSET) + CNT_W'(2)) begin
                  hb_we  = 1'b1;
                  hb_idx = 2'(cnt_ff - CNT_W'(hlen) - CNT_W'(HB_OFFSET));
               end
            end else if (cnt_ff == crcoff) begin
               if (xinfo.known) begin
                  crc_in = crc_step(crc_ff, xinfo.extra);
               end
               crc_lo_in = in_byte_ff;
            end else if (cnt_ff == crcoff + CNT_W'(1)) begin
               // all-zero afterwards means the received CRC matched
               crc_in = crc_ff ^ {in_byte_ff, crc_lo_ff};
            end
         end
         if (fexp_in != '0 && cnt_inc == CNT_W'(fexp_in)) begin
            emit    = 1'b1;
            cnt_in  = '0;
            fexp_in = '0;
            if (xinfo.known && crc_in != 16'h0000) begin
               err_in = err_ff + 32'd1;
            end
         end
      end
   end

   assign match = xinfo.known && (crc_in == 16'h0000);
   assign hb_ok = (cur_id == 24'd0) && match && (hdr_ff[1] >= HB_MIN_LEN);

   always_comb begin
      res_in.frame_length = cnt_inc[8:0];
      res_in.msg_num      = cur_id;
      res_in.src_sys      = v2 ? hdr_ff[5] : hdr_ff[3];
      res_in.src_comp     = v2 ? hdr_ff[6] : hdr_ff[4];
      res_in.is_v2        = v2;
      res_in.crc_status   = !xinfo.known ? CRC_UNKNOWN :
                            (match ? CRC_MATCH : CRC_MISMATCH);
      res_in.urgent       = in_priority_set(cur_id);
      res_in.hb_valid     = hb_ok;
      res_in.hb_armed     = hb_ok && hb_ff[2][HB_ARMED_BIT];
      res_in.hb_vehicle   = hb_ok ? hb_ff[0] : 8'h00;
      res_in.hb_autopilot = hb_ok ? hb_ff[1] : 8'h00;
      res_in.error_total  = err_in;
   end

   // a byte that finishes a frame waits only while the result register is still full
   assign advance      = in_valid_ff && (!emit || !rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.valid && req_ch.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         fexp_ff   <= '0;
         crc_ff    <= CRC_INIT;
         crc_lo_ff <= '0;
         err_ff    <= '0;
         for (int i = 0; i < HB_BYTES; i++) begin
            hb_ff[i] <= '0;
         end
      end else if (advance) begin
         cnt_ff    <= cnt_in;
         fexp_ff   <= fexp_in;
         crc_ff    <= crc_in;
         crc_lo_ff <= crc_lo_in;
         err_ff    <= err_in;
         if (hb_we) begin
            hb_ff[hb_idx] <= in_byte_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && hdr_we) begin
         hdr_ff[cnt_ff[HDR_IDX_W-1:0]] <= in_byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         res_ff <= res_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.frame_length = res_ff.frame_length;
   assign rsp_ch.msg_num      = res_ff.msg_num;
   assign rsp_ch.src_sys      = res_ff.src_sys;
   assign rsp_ch.src_comp     = res_ff.src_comp;
   assign rsp_ch.is_v2        = res_ff.is_v2;
   assign rsp_ch.crc_status   = res_ff.crc_status;
   assign rsp_ch.urgent       = res_ff.urgent;
   assign rsp_ch.hb_valid     = res_ff.hb_valid;
   assign rsp_ch.hb_armed     = res_ff.hb_armed;
   assign rsp_ch.hb_vehicle   = res_ff.hb_vehicle;
   assign rsp_ch.hb_autopilot = res_ff.hb_autopilot;
   assign rsp_ch.error_total  = res_ff.error_total;

endmodule

// ===== hdl/mfp_checker.sv =====
`timescale 1ns / 1ps

module mfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [23:0] msg_num,
   input logic        is_v2,
   input logic [1:0]  crc_status,
   input logic        hb_valid,
   input logic        hb_armed,
   input logic [7:0]  hb_vehicle,
   input logic [7:0]  hb_autopilot,
   input logic [31:0] error_total
);
   import mfp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result transaction dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(error_total) && $stable(msg_num))
      else $error("result payload changed while stalled");

   a_hb_needs_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && hb_valid |-> crc_status == CRC_MATCH && msg_num == 24'd0)
      else $error("heartbeat reported without matching CRC on id 0");

   a_hb_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !hb_valid |->
         !hb_armed && hb_vehicle == 8'h00 && hb_autopilot == 8'h00)
      else $error("heartbeat fields set without a valid heartbeat");

   a_v1_id_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !is_v2 |-> msg_num[23:8] == 16'h0000)
      else $error("v1 frame reported a message id wider than 8 bits");

endmodule

bind mavlink_frame_parser mfp_checker u_mfp_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .msg_num      (rsp_ch.msg_num),
   .is_v2        (rsp_ch.is_v2),
   .crc_status   (rsp_ch.crc_status),
   .hb_valid     (rsp_ch.hb_valid),
   .hb_armed     (rsp_ch.hb_armed),
   .hb_vehicle   (rsp_ch.hb_vehicle),
   .hb_autopilot (rsp_ch.hb_autopilot),
   .error_total  (rsp_ch.error_total)
);

// ===== sim/tb_mavlink_frame_parser.sv =====
`timescale 1ns / 1ps

import mfp_pkg::*;

// Tracks the parser byte by byte and holds the frame reports it should emit.
class frame_checker;
   bit [8:0]   known_ids [100];
   bit [7:0]   known_extras [100];

   bit [7:0]    hdr [10];
   int unsigned byte_count;
   int unsigned frame_len;
   bit [15:0]   crc;
   bit [7:0]    crc_lo;
   bit [7:0]    hb_bytes [3];
   bit [31:0]   error_count;

   result_type  pending_frames [$];
   int          failures;
   int          frames_seen;

   function new();
      known_ids = '{
           0,   1,   2,   4,  11,  20,  21,  22,  23,  24,  25,  26,  27,  29,  30,  31,
          32,  33,  35,  36,  37,  38,  39,  40,  41,  42,  43,  44,  45,  46,  47,  51,
          62,  65,  66,  69,  70,  73,  74,  75,  76,  77,  82,  84,  86, 109, 110, 111,
         125, 126, 147, 148, 152, 193, 230, 231, 241, 242, 245, 253, 254, 256, 257, 258,
         259, 260, 261, 262, 263, 264, 265, 266, 267, 268, 269, 270, 280, 281, 282, 283,
         284, 285, 286, 287, 288, 299, 301, 310, 311, 320, 321, 322, 323, 324, 330, 331,
         332, 333, 334, 335};
      known_extras = '{
          50, 124, 137, 237,  89, 214, 159, 220, 168,  24,  23, 170, 144, 115,  39, 246,
         185, 104, 244, 222, 212,   9, 254, 230,  28,  28, 132, 221, 232,  11, 153, 196,
         183, 118, 148, 243, 124,  38,  20, 158, 152, 143,  49, 143,   5, 185,  84,  34,
         203, 220, 154, 178, 208,  71, 163, 105,  90, 104, 130,  83,  46,  71, 131, 187,
          92, 146, 179,  12, 133,  49,  26, 193,  35,  14, 109,  59,  70,  48, 123,  74,
          99, 137, 210,   1,  20,  19, 243,  28,  95, 243,  88, 243,  78, 132,  23,  91,
         236, 231,  72, 225};
      byte_count  = 0;
      frame_len   = 0;
      crc         = 16'hFFFF;
      crc_lo      = 8'h00;
      error_count = 0;
      failures    = 0;
      frames_seen = 0;
      foreach (hb_bytes[i]) hb_bytes[i] = 8'h00;
      foreach (hdr[i]) hdr[i] = 8'h00;
   endfunction

   // CRC-16/MCRF4XX over one byte
   function bit [15:0] crc_next(bit [15:0] c, bit [7:0] d);
      bit [7:0]  t;
      bit [15:0] w;
      t = d ^ c[7:0];
      t = t ^ {t[3:0], 4'h0};
      w = {8'h00, t};
      return {8'h00, c[15:8]} ^ (w << 8) ^ (w << 3) ^ (w >> 4);
   endfunction

   // {known, extra byte}
   function bit [8:0] extra_lookup(bit [23:0] id);
      foreach (known_ids[i]) begin
         if (id == {15'd0, known_ids[i]}) return {1'b1, known_extras[i]};
      end
      return 9'h000;
   endfunction

   function bit urgent_id(bit [23:0] id);
      return id == 11 || id == 23 || id == 69 || id == 70 || id == 75 || id == 76 ||
             id == 77 || (id >= 37 && id <= 51) || id == 66 || id == 82 || id == 84 ||
             id == 86 || id == 110 || (id >= 282 && id <= 288);
   endfunction

   function bit [23:0] msg_id(bit v2);
      return v2 ? {hdr[9], hdr[8], hdr[7]} : {16'h0000, hdr[5]};
   endfunction

   function void note_byte(bit [7:0] b);
      int unsigned pos;
      int unsigned hlen;
      int unsigned crc_pos;
      bit          v2;
      bit          known;
      bit          good;
      bit          hb_ok;
      bit [8:0]    ex;
      bit [23:0]   id;
      result_type  r;

      if (byte_count == 0) begin
         if (b != MAGIC_V1 && b != MAGIC_V2) return;
         hdr[0]     = b;
         byte_count = 1;
         frame_len  = 0;
         crc        = 16'hFFFF;
         return;
      end
      if (byte_count >= MAX_FRAME_BYTES) begin
         error_count++;
         byte_count = 0;
         frame_len  = 0;
         return;
      end
      pos = byte_count;
      if (pos < 10) hdr[pos] = b;
      byte_count = pos + 1;
      v2   = (hdr[0] == MAGIC_V2);
      hlen = v2 ? 10 : 6;

      if (pos == 1) begin
         frame_len = (v2 ? 12 : 8) + b;
         crc       = crc_next(crc, b);
      end else begin
         crc_pos = hlen + hdr[1];
         // signed v2 frame: trailing signature
         if (v2 && byte_count == 3 && b[0]) frame_len += 13;
         if (pos < crc_pos) begin
            crc = crc_next(crc, b);
            if (pos >= hlen + 4 && pos <= hlen + 6) hb_bytes[pos - hlen - 4] = b;
         end else if (pos == crc_pos) begin
            ex = extra_lookup(msg_id(v2));
            if (ex[8]) crc = crc_next(crc, ex[7:0]);
            crc_lo = b;
         end else if (pos == crc_pos + 1) begin
            crc = crc ^ {b, crc_lo};
         end
      end

      if (frame_len == 0 || byte_count != frame_len) return;

      id    = msg_id(v2);
      ex    = extra_lookup(id);
      known = ex[8];
      good  = known && crc == 16'h0000;
      if (known && !good) error_count++;
      hb_ok = id == 0 && good && hdr[1] >= 9;

      r.frame_length = byte_count[8:0];
      r.msg_num      = id;
      r.src_sys      = hdr[v2 ? 5 : 3];
      r.src_comp     = hdr[v2 ? 6 : 4];
      r.is_v2        = v2;
      r.crc_status   = !known ? CRC_UNKNOWN : (good ? CRC_MATCH : CRC_MISMATCH);
      r.urgent       = urgent_id(id);
      r.hb_valid     = hb_ok;
      r.hb_armed     = hb_ok && hb_bytes[2][7];
      r.hb_vehicle   = hb_ok ? hb_bytes[0] : 8'h00;
      r.hb_autopilot = hb_ok ? hb_bytes[1] : 8'h00;
      r.error_total  = error_count;
      pending_frames.push_back(r);

      byte_count = 0;
      frame_len  = 0;
   endfunction

   task flag(string msg);
      failures++;
      $display("MISMATCH: %s", msg);
   endtask

   task cmp(string field, longint unsigned seen, longint unsigned want);
      if (seen != want)
         flag($sformatf("frame %0d %s: got 0x%0h, expected 0x%0h",
                        frames_seen, field, seen, want));
   endtask

   task check_report(result_type got);
      result_type want;
      if (pending_frames.size() == 0) begin
         flag($sformatf("frame report with no frame pending (length %0d, id 0x%0h)",
                        got.frame_length, got.msg_num));
         return;
      end
      want = pending_frames.pop_front();
      cmp("frame_length", got.frame_length, want.frame_length);
      cmp("msg_num", got.msg_num, want.msg_num);
      cmp("src_sys", got.src_sys, want.src_sys);
      cmp("src_comp", got.src_comp, want.src_comp);
      cmp("is_v2", got.is_v2, want.is_v2);
      cmp("crc_status", got.crc_status, want.crc_status);
      cmp("urgent", got.urgent, want.urgent);
      cmp("hb_valid", got.hb_valid, want.hb_valid);
      cmp("hb_armed", got.hb_armed, want.hb_armed);
      cmp("hb_vehicle", got.hb_vehicle, want.hb_vehicle);
      cmp("hb_autopilot", got.hb_autopilot, want.hb_autopilot);
      cmp("error_total", got.error_total, want.error_total);
      frames_seen++;
   endtask
endclass

module tb_mavlink_frame_parser;

   localparam int CYCLE_LIMIT = 500000;

   logic clock;
   logic reset;

   mfp_req_if req_bus ();
   mfp_rsp_if rsp_bus ();

   mavlink_frame_parser u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   frame_checker chk;
   result_type   seen;
   int           idle_pct;
   int           stall_pct;
   int           sent_bytes;
   int           cycle_count;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.byte_in = 8'h00;
      rsp_bus.ready   = 1'b0;
      idle_pct        = 0;
      stall_pct       = 0;
      sent_bytes      = 0;
      cycle_count     = 0;
      chk             = new();
   end

   always @(negedge clock) rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) chk.note_byte(req_bus.byte_in);
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.frame_length = rsp_bus.frame_length;
            seen.msg_num      = rsp_bus.msg_num;
            seen.src_sys      = rsp_bus.src_sys;
            seen.src_comp     = rsp_bus.src_comp;
            seen.is_v2        = rsp_bus.is_v2;
            seen.crc_status   = crc_status_type'(rsp_bus.crc_status);
            seen.urgent       = rsp_bus.urgent;
            seen.hb_valid     = rsp_bus.hb_valid;
            seen.hb_armed     = rsp_bus.hb_armed;
            seen.hb_vehicle   = rsp_bus.hb_vehicle;
            seen.hb_autopilot = rsp_bus.hb_autopilot;
            seen.error_total  = rsp_bus.error_total;
            chk.check_report(seen);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic send_byte(input bit [7:0] b);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.byte_in <= b;
      do @(posedge clock); while (!req_bus.ready);
      sent_bytes++;
      @(negedge clock);
   endtask

   // Builds a frame with a CRC that matches unless corrupted; broken frames lose their tail.
   task automatic send_frame(input bit v2, input bit signed_f, input int len,
                             input bit [23:0] id, input bit corrupt, input bit broken);
      bit [7:0]  fr [$];
      bit [7:0]  r;
      bit [15:0] c;
      bit [8:0]  ex;
      int        keep;
      r = 8'($urandom);
      fr.push_back(v2 ? MAGIC_V2 : MAGIC_V1);
      fr.push_back(len[7:0]);
      if (v2) begin
         fr.push_back({r[7:1], signed_f});
         fr.push_back(8'($urandom));
      end
      fr.push_back(8'($urandom));
      fr.push_back(8'($urandom));
      fr.push_back(8'($urandom));
      fr.push_back(id[7:0]);
      if (v2) begin
         fr.push_back(id[15:8]);
         fr.push_back(id[23:16]);
      end
      for (int i = 0; i < len; i++) fr.push_back(8'($urandom));
      c = 16'hFFFF;
      for (int i = 1; i < fr.size(); i++) c = chk.crc_next(c, fr[i]);
      ex = chk.extra_lookup(v2 ? id : {16'h0000, id[7:0]});
      if (ex[8]) c = chk.crc_next(c, ex[7:0]);
      if (corrupt) c = c ^ 16'($urandom_range(1, 65535));
      fr.push_back(c[7:0]);
      fr.push_back(c[15:8]);
      if (signed_f) for (int i = 0; i < 13; i++) fr.push_back(8'($urandom));
      keep = broken ? $urandom_range(1, fr.size() - 1) : fr.size();
      for (int i = 0; i < keep; i++) send_byte(fr[i]);
   endtask

   task automatic send_random_frame(input int k);
      int        sel;
      int        len;
      int        n;
      bit        v2;
      bit        signed_f;
      bit        corrupt;
      bit        broken;
      bit [23:0] id;
      bit [7:0]  nb;
      sel = $urandom_range(0, 99);
      len = $urandom_range(0, 20);
      v2  = $urandom_range(0, 1);
      if (sel < 15) begin
         // heartbeat, mostly with a full payload
         id = 24'd0;
         if ($urandom_range(0, 3) != 0) len = $urandom_range(9, 16);
      end else if (sel < 60) begin
         id = {15'd0, chk.known_ids[$urandom_range(0, 99)]};
      end else if (sel < 70) begin
         id = $urandom_range(0, 1) ? 24'($urandom_range(30, 115)) : 24'($urandom_range(278, 292));
      end else begin
         id = v2 ? 24'($urandom) : 24'($urandom_range(0, 255));
      end
      if (id > 255) v2 = 1'b1;
      signed_f = v2 && $urandom_range(0, 3) == 0;
      if (k % 37 == 5) len = 255;
      if (k % 74 == 5) begin
         v2       = 1'b1;
         signed_f = 1'b1;
      end
      corrupt = $urandom_range(0, 7) == 0;
      broken  = $urandom_range(0, 29) == 0;
      if ($urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++) begin
            do nb = 8'($urandom); while (nb == MAGIC_V1 || nb == MAGIC_V2);
            send_byte(nb);
         end
      end
      send_frame(v2, signed_f, len, id, corrupt, broken);
   endtask

   initial begin
      int frame_no;
      int phase_end;
      frame_no = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: hunting noise, shortest v1 heartbeat id, unknown max v2 id
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h7F);
      send_frame(1'b0, 1'b0, 0, 24'd0, 1'b0, 1'b0);
      send_frame(1'b1, 1'b0, 0, 24'hFFFFFF, 1'b0, 1'b0);

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 61; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 61; end
            default: begin idle_pct = 15; stall_pct = 15; end
         endcase
         phase_end = sent_bytes + 345;
         while (sent_bytes < phase_end) begin
            send_random_frame(frame_no);
            frame_no++;
         end
      end
      req_bus.valid <= 1'b0;

      while (chk.pending_frames.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (chk.failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/mfp_pkg.sv
hdl/mfp_if.sv
hdl/mavlink_frame_parser.sv
hdl/mfp_checker.sv
sim/tb_mavlink_frame_parser.sv
